@@ hw/rtl/spmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared sizes, codes and structs of the strict priority multi FIFO.
// ----------------------------------------------------------------------------
package spmf_pkg;

    localparam int MAX_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int ID_BITS     = 16;

    localparam int STORE_W  = (ID_BITS < 16) ? ID_BITS : 16;
    localparam int STORE_SZ = MAX_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W   = (STORE_SZ > 1) ? $clog2(STORE_SZ) : 1;
    localparam int PTR_W    = $clog2(LEVEL_DEPTH);
    localparam int FILL_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int LNUM_W   = $clog2(MAX_LEVELS + 1);
    localparam int TOT_W    = $clog2(STORE_SZ + 1);

    localparam logic [3:0] LEVELS_RESET = 4'd8;

    typedef logic [STORE_W-1:0] id_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [FILL_W-1:0]  fill_t;

    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_DEQ   = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic  en;
        logic  we;
        addr_t waddr;
        addr_t raddr_rem;
        addr_t raddr_head;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic               removed_valid;
        logic [LNUM_W-1:0]  head_prio;
        logic [TOT_W-1:0]   total;
        fill_t              level_count;
    } res_t;

endpackage

@@ hw/rtl/spmf_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_store
// Task word store: one write port, two registered read ports with write
// forwarding on the head port.
// ----------------------------------------------------------------------------
module spmf_store (
    input  logic              aclk,
    input  spmf_pkg::mem_req_t req,
    input  spmf_pkg::id_t     wdata,
    output spmf_pkg::id_t     rd_rem,
    output spmf_pkg::id_t     rd_head
);
    import spmf_pkg::*;

    id_t mem [STORE_SZ];
    id_t rd_rem_reg;
    id_t rd_head_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= wdata;
        end
        if (req.en) begin
            rd_rem_reg <= mem[req.raddr_rem];
            if (req.we && (req.waddr == req.raddr_head)) begin
                rd_head_reg <= wdata;
            end else begin
                rd_head_reg <= mem[req.raddr_head];
            end
        end
    end

    assign rd_rem  = rd_rem_reg;
    assign rd_head = rd_head_reg;

endmodule

@@ hw/rtl/spmf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_ctrl
// Per-level pointers and fill counts, priority select and result fields for
// one word per cycle while step_en is high.
// ----------------------------------------------------------------------------
module spmf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [3:0]         levels,
    input  spmf_pkg::mode_t    mode,
    input  logic [3:0]         prio,
    output spmf_pkg::mem_req_t req,
    output spmf_pkg::res_t     res
);
    import spmf_pkg::*;

    ptr_t  front_reg [MAX_LEVELS];
    ptr_t  rear_reg  [MAX_LEVELS];
    fill_t fill_reg  [MAX_LEVELS];
    ptr_t  front_next [MAX_LEVELS];
    ptr_t  rear_next  [MAX_LEVELS];
    fill_t fill_next  [MAX_LEVELS];

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_inc = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic addr_t addr_of(input int lvl, input ptr_t p);
        addr_of = ADDR_W'(lvl * LEVEL_DEPTH + int'(p));
    endfunction

    always_comb begin
        logic [LNUM_W-1:0]     n_act;
        logic [MAX_LEVELS-1:0] active;
        logic [MAX_LEVELS-1:0] match;
        logic [MAX_LEVELS-1:0] top_oh;
        logic [MAX_LEVELS-1:0] top2_oh;
        logic [MAX_LEVELS-1:0] sel_enq;
        logic [MAX_LEVELS-1:0] sel_deq;
        logic                  found;
        logic                  prio_ok;
        logic                  full_sel;
        logic                  is_enq;
        logic                  is_deq;
        logic                  enq_ok;
        logic                  deq_ok;
        logic [TOT_W-1:0]      tot;

        if (int'(levels) > MAX_LEVELS) begin
            n_act = LNUM_W'(MAX_LEVELS);
        end else begin
            n_act = LNUM_W'(levels);
        end
        prio_ok = (prio != 4'd0) && (int'(prio) <= int'(n_act));

        is_enq = 1'b0;
        is_deq = 1'b0;
        case (mode)
            MODE_ENQ: is_enq = 1'b1;
            MODE_DEQ: is_deq = 1'b1;
            default:  ;
        endcase

        full_sel = 1'b0;
        for (int j = 0; j < MAX_LEVELS; j++) begin
            active[j] = (j < int'(n_act));
            match[j]  = prio_ok && (int'(prio) == j + 1);
            full_sel  = full_sel | (match[j] && (fill_reg[j] == FILL_W'(LEVEL_DEPTH)));
        end

        found = 1'b0;
        for (int j = MAX_LEVELS - 1; j >= 0; j--) begin
            top_oh[j] = !found && active[j] && (fill_reg[j] != '0);
            found     = found | top_oh[j];
        end

        enq_ok = is_enq && prio_ok && !full_sel;
        deq_ok = is_deq && found;

        for (int j = 0; j < MAX_LEVELS; j++) begin
            sel_enq[j]    = enq_ok && match[j];
            sel_deq[j]    = deq_ok && top_oh[j];
            fill_next[j]  = fill_reg[j] + FILL_W'(sel_enq[j]) - FILL_W'(sel_deq[j]);
            front_next[j] = sel_deq[j] ? ptr_inc(front_reg[j]) : front_reg[j];
            rear_next[j]  = sel_enq[j] ? ptr_inc(rear_reg[j]) : rear_reg[j];
        end

        found = 1'b0;
        for (int j = MAX_LEVELS - 1; j >= 0; j--) begin
            top2_oh[j] = !found && active[j] && (fill_next[j] != '0);
            found      = found | top2_oh[j];
        end

        req            = '0;
        res            = '0;
        req.en         = step_en;
        req.we         = step_en && enq_ok;
        tot            = '0;
        for (int j = 0; j < MAX_LEVELS; j++) begin
            if (sel_enq[j]) begin
                req.waddr = req.waddr | addr_of(j, rear_reg[j]);
            end
            if (top_oh[j]) begin
                req.raddr_rem = req.raddr_rem | addr_of(j, front_reg[j]);
            end
            if (top2_oh[j]) begin
                req.raddr_head = req.raddr_head | addr_of(j, front_next[j]);
                res.head_prio  = res.head_prio | LNUM_W'(j + 1);
            end
            if (match[j]) begin
                res.level_count = res.level_count | fill_next[j];
            end
            if (active[j]) begin
                tot = tot + TOT_W'(fill_next[j]);
            end
        end
        res.total         = tot;
        res.removed_valid = deq_ok;

        if (is_enq && !prio_ok) begin
            res.status = ST_RANGE;
        end else if (is_enq && full_sel) begin
            res.status = ST_FULL;
        end else if (is_deq && !deq_ok) begin
            res.status = ST_EMPTY;
        end else begin
            res.status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_LEVELS; j++) begin
                front_reg[j] <= '0;
                rear_reg[j]  <= '0;
                fill_reg[j]  <= '0;
            end
        end else if (step_en) begin
            for (int j = 0; j < MAX_LEVELS; j++) begin
                front_reg[j] <= front_next[j];
                rear_reg[j]  <= rear_next[j];
                fill_reg[j]  <= fill_next[j];
            end
        end
    end

endmodule

@@ hw/rtl/strict_priority_multi_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// Bank of per-priority task FIFOs with strict highest-level-first dequeue.
//
// Input channel s_*: one word carries a mode (enqueue, dequeue, query), a
// priority level and a task ID. Result channel m_*: one word per input word
// with status, removed task, head task and level, total and per-level count.
// cfg_we/cfg_wdata write levels_in_use; write it only while the block idles.
// An accepted word passes the input register, then the result register,
// which also latches the task store read ports.
// Throughput: one word per cycle while m_ready stays high, set by the pointer
// update and priority select feeding the store's registered read ports.
// Reset: all levels empty, levels_in_use back to 8; no clearing pass, the
// store's read data is used only for occupied entries.
// Stall: while m_ready is low the result holds, the input register holds one
// more word, and s_ready drops once both are full.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_priority_req,
    input  logic [15:0] s_task_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_removed_task,
    output logic        m_removed_valid,
    output logic [15:0] m_head_task,
    output logic [3:0]  m_head_priority,
    output logic [7:0]  m_total_count,
    output logic [4:0]  m_level_count
);
    import spmf_pkg::*;

    logic [3:0] levels_val_reg;
    logic       in_valid_reg;
    logic [1:0] mode_reg;
    logic [3:0] prio_reg;
    id_t        tid_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       res_reg;
    res_t       res;
    mem_req_t   req;
    id_t        rd_rem;
    id_t        rd_head;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_val_reg <= LEVELS_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                levels_val_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            mode_reg <= s_mode;
            prio_reg <= s_priority_req;
            tid_reg  <= s_task_id[STORE_W-1:0];
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    spmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .levels  (levels_val_reg),
        .mode    (mode_t'(mode_reg)),
        .prio    (prio_reg),
        .req     (req),
        .res     (res)
    );

    spmf_store u_store (
        .aclk    (aclk),
        .req     (req),
        .wdata   (tid_reg),
        .rd_rem  (rd_rem),
        .rd_head (rd_head)
    );

    assign m_valid         = out_valid_reg;
    assign m_status        = res_reg.status;
    assign m_removed_valid = res_reg.removed_valid;
    assign m_removed_task  = res_reg.removed_valid ? 16'(rd_rem) : 16'd0;
    assign m_head_task     = (res_reg.head_prio != '0) ? 16'(rd_head) : 16'd0;
    assign m_head_priority = 4'(res_reg.head_prio);
    assign m_total_count   = 8'(res_reg.total);
    assign m_level_count   = 5'(res_reg.level_count);

endmodule

@@ tb/strict_priority_multi_fifo_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo_tb
// Self-checking bench for the per-priority task FIFO bank. A short scripted
// sequence covers reset state, range and empty errors, hidden levels and
// register saturation. Random phases at several level settings follow. They
// fill levels to the top, wrap the ring pointers, and drain them again
// under varied source and sink throttling. Every word is checked field by
// field against a behavioral model of the queues kept inside the bench.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_tb;

    import spmf_pkg::*;

    localparam logic [1:0] MODE_SPARE     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        status_t     status;
        logic [15:0] removed_task;
        logic        removed_valid;
        logic [15:0] head_task;
        logic [3:0]  head_priority;
        logic [7:0]  total_count;
        logic [4:0]  level_count;
    } queue_report_t;

    localparam queue_report_t NO_REPORT = '0;

    typedef enum {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic [3:0]    levels;
        logic [1:0]    mode;
        logic [3:0]    prio;
        logic [15:0]   task_id;
        bit            fixed;
        queue_report_t want;
    } script_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [3:0]  s_priority_req;
    logic [15:0] s_task_id;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_removed_task;
    logic        m_removed_valid;
    logic [15:0] m_head_task;
    logic [3:0]  m_head_priority;
    logic [7:0]  m_total_count;
    logic [4:0]  m_level_count;

    logic [15:0] held_ids [0:MAX_LEVELS-1][0:LEVEL_DEPTH-1];
    int          rd_slot  [0:MAX_LEVELS-1];
    int          wr_slot  [0:MAX_LEVELS-1];
    int          fill     [0:MAX_LEVELS-1];
    logic [3:0]  levels_reg;

    queue_report_t pending_reports[$];
    script_row_t   directed_rows[$];
    int            mismatches;
    int            idle_cycles;
    int            src_gap_pct;
    int            sink_stall_pct;
    int            ready_hold_len;

    strict_priority_multi_fifo i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_priority_req  (s_priority_req),
        .s_task_id       (s_task_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_task  (m_removed_task),
        .m_removed_valid (m_removed_valid),
        .m_head_task     (m_head_task),
        .m_head_priority (m_head_priority),
        .m_total_count   (m_total_count),
        .m_level_count   (m_level_count)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic int visible_levels();
        return (levels_reg > MAX_LEVELS) ? MAX_LEVELS : int'(levels_reg);
    endfunction

    function automatic int top_visible();
        for (int l = visible_levels(); l >= 1; l--) begin
            if (fill[l-1] != 0) return l;
        end
        return 0;
    endfunction

    function automatic queue_report_t apply_queue_op(input logic [1:0] md,
                                                     input logic [3:0] pr,
                                                     input logic [15:0] id);
        queue_report_t r;
        int            n;
        int            p;
        int            top;
        bit            pr_ok;
        n     = visible_levels();
        p     = int'(pr);
        pr_ok = (p >= 1) && (p <= n);
        r     = NO_REPORT;
        if (md == MODE_ENQ) begin
            if (!pr_ok) begin
                r.status = ST_RANGE;
            end else if (fill[p-1] >= LEVEL_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                held_ids[p-1][wr_slot[p-1]] = id;
                wr_slot[p-1] = (wr_slot[p-1] + 1) % LEVEL_DEPTH;
                fill[p-1]++;
            end
        end else if (md == MODE_DEQ) begin
            top = top_visible();
            if (top == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed_task  = held_ids[top-1][rd_slot[top-1]];
                r.removed_valid = 1'b1;
                rd_slot[top-1]  = (rd_slot[top-1] + 1) % LEVEL_DEPTH;
                fill[top-1]--;
            end
        end
        top = top_visible();
        r.head_priority = 4'(top);
        if (top != 0) r.head_task = held_ids[top-1][rd_slot[top-1]];
        for (int l = 0; l < n; l++) r.total_count += 8'(fill[l]);
        if (pr_ok) r.level_count = 5'(fill[p-1]);
        return r;
    endfunction

    function automatic queue_report_t report(input status_t st, input logic [15:0] rem,
                                             input logic rv, input logic [15:0] hd,
                                             input logic [3:0] hp, input logic [7:0] tot,
                                             input logic [4:0] lc);
        queue_report_t r;
        r = '{st, rem, rv, hd, hp, tot, lc};
        return r;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [3:0] lv,
                                    input logic [1:0] md, input logic [3:0] pr,
                                    input logic [15:0] id, input bit fixed,
                                    input queue_report_t want);
        script_row_t row;
        row = '{kind, lv, md, pr, id, fixed, want};
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_word(input logic [1:0] md, input logic [3:0] pr,
                             input logic [15:0] id, input bit fixed,
                             input queue_report_t want);
        queue_report_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_mode         = md;
        s_priority_req = pr;
        s_task_id      = id;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_queue_op(md, pr, id);
        pending_reports.push_back(fixed ? want : predicted);
    endtask

    // drop valid and wait for every outstanding word to return
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_levels(input logic [3:0] lv);
        settle();
        @(negedge aclk);
        cfg_we     = 1'b1;
        cfg_wdata  = lv;
        levels_reg = lv;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(input logic [3:0] lv, input int gap_pct, input int stall_pct,
                             input int enq_pct, input int deq_pct, input int words,
                             input int hold, input int drain_every);
        logic [1:0] md;
        logic [3:0] pr;
        int         roll;
        int         n;
        write_levels(lv);
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        ready_hold_len = hold;
        n = visible_levels();
        for (int k = 0; k < words; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < enq_pct) md = MODE_ENQ;
            else if (roll < enq_pct + deq_pct) md = MODE_DEQ;
            else md = $urandom_range(0, 1) ? MODE_QUERY : MODE_SPARE;
            if (n > 0 && $urandom_range(0, 99) < 85) pr = 4'($urandom_range(1, n));
            else pr = 4'($urandom_range(0, 15));
            send_word(md, pr, 16'($urandom_range(0, 65535)), 1'b0, NO_REPORT);
            if (drain_every != 0 && (k + 1) % drain_every == 0) settle();
        end
    endtask

    // sink side: long hold on request, otherwise random stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold_len != 0) begin
                m_ready = 1'b0;
                repeat (ready_hold_len) @(negedge aclk);
                ready_hold_len = 0;
            end
            m_ready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result word with no outstanding request");
                mismatches++;
            end else begin
                queue_report_t want;
                want = pending_reports.pop_front();
                check_field("status",        32'(want.status),        32'(m_status));
                check_field("removed_task",  32'(want.removed_task),  32'(m_removed_task));
                check_field("removed_valid", 32'(want.removed_valid), 32'(m_removed_valid));
                check_field("head_task",     32'(want.head_task),     32'(m_head_task));
                check_field("head_priority", 32'(want.head_priority), 32'(m_head_priority));
                check_field("total_count",   32'(want.total_count),   32'(m_total_count));
                check_field("level_count",   32'(want.level_count),   32'(m_level_count));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("strict_priority_multi_fifo_tb: FAIL");
            $finish;
        end
    end

    initial begin
        script_row_t row;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 4'd0;
        s_valid        = 1'b0;
        s_mode         = MODE_QUERY;
        s_priority_req = 4'd0;
        s_task_id      = 16'h0000;
        mismatches     = 0;
        idle_cycles    = 0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        ready_hold_len = 0;
        levels_reg     = LEVELS_RESET;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            rd_slot[l] = 0;
            wr_slot[l] = 0;
            fill[l]    = 0;
        end

        add_row(ROW_WORD, 0, MODE_QUERY, 4'd0, 16'h0000, 1, report(ST_OK, 0, 0, 0, 0, 0, 0));
        add_row(ROW_WORD, 0, MODE_DEQ, 4'd0, 16'h0000, 1, report(ST_EMPTY, 0, 0, 0, 0, 0, 0));
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd0, 16'hFFFF, 1, report(ST_RANGE, 0, 0, 0, 0, 0, 0));
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd15, 16'h0000, 1, report(ST_RANGE, 0, 0, 0, 0, 0, 0));
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd9, 16'h1234, 1, report(ST_RANGE, 0, 0, 0, 0, 0, 0));
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd1, 16'hFFFF, 1,
                report(ST_OK, 0, 0, 16'hFFFF, 4'd1, 8'd1, 5'd1));
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd8, 16'h0000, 1,
                report(ST_OK, 0, 0, 16'h0000, 4'd8, 8'd2, 5'd1));
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd8, 16'hA5A5, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd4, 16'h5A5A, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_SPARE, 4'd8, 16'hFFFF, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_DEQ, 4'd8, 16'h0000, 0, NO_REPORT);
        add_row(ROW_CFG, 4'd0, MODE_QUERY, 0, 0, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd1, 16'h7777, 1, report(ST_RANGE, 0, 0, 0, 0, 0, 0));
        add_row(ROW_WORD, 0, MODE_DEQ, 4'd1, 16'h0000, 1, report(ST_EMPTY, 0, 0, 0, 0, 0, 0));
        add_row(ROW_WORD, 0, MODE_QUERY, 4'd1, 16'h0000, 1, report(ST_OK, 0, 0, 0, 0, 0, 0));
        add_row(ROW_CFG, 4'd15, MODE_QUERY, 0, 0, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_QUERY, 4'd8, 16'h0000, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_ENQ, 4'd9, 16'h8001, 0, NO_REPORT);
        add_row(ROW_CFG, 4'd1, MODE_QUERY, 0, 0, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_QUERY, 4'd4, 16'h0000, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_DEQ, 4'd1, 16'h0000, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_DEQ, 4'd1, 16'h0000, 0, NO_REPORT);
        add_row(ROW_CFG, 4'd8, MODE_QUERY, 0, 0, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_DEQ, 4'd8, 16'h0000, 0, NO_REPORT);
        add_row(ROW_WORD, 0, MODE_SPARE, 4'd4, 16'h0000, 0, NO_REPORT);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                write_levels(row.levels);
            end else begin
                send_word(row.mode, row.prio, row.task_id, row.fixed, row.want);
            end
        end

        run_phase(4'd8,  0,  0,  60, 25, 150, 0,  0);
        run_phase(4'd8,  76, 0,  85, 5,  200, 0,  0);
        run_phase(4'd3,  0,  76, 40, 45, 120, 0,  0);
        run_phase(4'd15, 29, 29, 30, 60, 150, 0,  0);
        run_phase(4'd1,  0,  0,  70, 20, 100, 60, 0);
        run_phase(4'd0,  29, 29, 40, 40, 40,  0,  0);
        run_phase(4'd5,  0,  76, 55, 35, 120, 0,  0);
        run_phase(4'd8,  0,  0,  50, 40, 150, 80, 25);
        run_phase(4'd2,  76, 0,  55, 35, 120, 0,  0);
        run_phase(4'd7,  29, 29, 45, 45, 150, 0,  0);
        run_phase(4'd8,  0,  76, 35, 60, 150, 0,  0);
        run_phase(4'd6,  0,  0,  50, 40, 70,  0,  0);

        settle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("strict_priority_multi_fifo_tb: PASS");
        end else begin
            $display("strict_priority_multi_fifo_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/spmf_pkg.sv
hw/rtl/spmf_store.sv
hw/rtl/spmf_ctrl.sv
hw/rtl/strict_priority_multi_fifo.sv
tb/strict_priority_multi_fifo_tb.sv
